// ===== rtl/ttce_pkg.sv =====
// Shared types, codes and defaults for the text terminal cursor engine.
package ttce_pkg;

    localparam int COLS_DEFAULT     = 80;
    localparam int ROWS_DEFAULT     = 25;
    localparam int TAB_STOP_DEFAULT = 8;

    // Transaction kinds.
    localparam logic [1:0] KIND_PUT   = 2'd0;
    localparam logic [1:0] KIND_SET   = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    // Character codes handled by a put.
    localparam logic [7:0] CH_BS         = 8'h08;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_LAST_PRINT = 8'h7F;

    localparam logic [15:0] BLANK_WHITE = 16'h0F20;
    localparam logic [15:0] BLANK_BLACK = 16'h0020;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_SCROLL,
        S_CLEAR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic sweep_run;
        logic sweep_copy;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       need_scroll;
        logic       sweep_last;
    } t_dp_status;

endpackage

// ===== rtl/text_terminal_cursor_engine_top.sv =====
// Top level of the text terminal cursor engine: controller and datapath.
//
//  Channel  | Handshake                    | Payload
//  ---------+------------------------------+------------------------------------------
//  command  | start in, busy out           | i_kind, i_char_code, i_back_colour,
//           | (taken when start && !busy)  | i_fore_colour, i_new_col, i_new_row,
//           |                              | i_cell_index
//  result   | o_valid out, one-cycle pulse | o_cursor_col, o_cursor_row,
//           |                              | o_cursor_location, o_scrolled, o_cell_data
//
// A put that needs no scroll, a set cursor or a read cell goes through accept, execute
// (one memory access) and result strobe before the next transaction can be taken.
// A scroll or clear sweeps the whole screen memory, one cell a cycle on its single
// write port.
// After reset the memory is blanked by a sweep over all cells during which busy is high.
// The result is shown for exactly one cycle; the receiver cannot stall it.
module text_terminal_cursor_engine_top #(
    parameter int COLS     = ttce_pkg::COLS_DEFAULT,
    parameter int ROWS     = ttce_pkg::ROWS_DEFAULT,
    parameter int TAB_STOP = ttce_pkg::TAB_STOP_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_char_code,
    input  logic [3:0]  i_back_colour,
    input  logic [3:0]  i_fore_colour,
    input  logic [6:0]  i_new_col,
    input  logic [4:0]  i_new_row,
    input  logic [10:0] i_cell_index,
    output logic        o_valid,
    output logic [6:0]  o_cursor_col,
    output logic [4:0]  o_cursor_row,
    output logic [10:0] o_cursor_location,
    output logic        o_scrolled,
    output logic [15:0] o_cell_data
);

    ttce_pkg::t_dp_cmd    cmd;
    ttce_pkg::t_dp_status status;

    ttce_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_valid  (o_valid),
        .i_status (status),
        .o_cmd    (cmd)
    );

    ttce_dp #(
        .COLS     (COLS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_kind            (i_kind),
        .i_char_code       (i_char_code),
        .i_back_colour     (i_back_colour),
        .i_fore_colour     (i_fore_colour),
        .i_new_col         (i_new_col),
        .i_new_row         (i_new_row),
        .i_cell_index      (i_cell_index),
        .o_cursor_col      (o_cursor_col),
        .o_cursor_row      (o_cursor_row),
        .o_cursor_location (o_cursor_location),
        .o_scrolled        (o_scrolled),
        .o_cell_data       (o_cell_data)
    );

endmodule

// ===== rtl/ttce_ctrl.sv =====
// Controller state machine: sequences execution, screen sweeps and the result strobe.
module ttce_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    output logic                  o_valid,
    input  ttce_pkg::t_dp_status  i_status,
    output ttce_pkg::t_dp_cmd     o_cmd
);

    ttce_pkg::t_state r_state;
    ttce_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ttce_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        busy      = 1'b1;
        o_valid   = 1'b0;
        case (r_state)
            ttce_pkg::S_INIT: begin
                o_cmd.sweep_run = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = ttce_pkg::S_IDLE;
                end
            end
            ttce_pkg::S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ttce_pkg::S_EXEC;
                end
            end
            ttce_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                case (i_status.kind)
                    ttce_pkg::KIND_PUT: begin
                        n_state = i_status.need_scroll ? ttce_pkg::S_SCROLL : ttce_pkg::S_DONE;
                    end
                    ttce_pkg::KIND_CLEAR: begin
                        n_state = ttce_pkg::S_CLEAR;
                    end
                    default: begin
                        n_state = ttce_pkg::S_DONE;
                    end
                endcase
            end
            ttce_pkg::S_SCROLL: begin
                o_cmd.sweep_run  = 1'b1;
                o_cmd.sweep_copy = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = ttce_pkg::S_DONE;
                end
            end
            ttce_pkg::S_CLEAR: begin
                o_cmd.sweep_run = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = ttce_pkg::S_DONE;
                end
            end
            ttce_pkg::S_DONE: begin
                o_valid = 1'b1;
                n_state = ttce_pkg::S_IDLE;
            end
            default: begin
                n_state = ttce_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/ttce_dp.sv =====
// Datapath: cursor registers, put decoding, the screen memory and its sweep engine.
module ttce_dp #(
    parameter int COLS     = ttce_pkg::COLS_DEFAULT,
    parameter int ROWS     = ttce_pkg::ROWS_DEFAULT,
    parameter int TAB_STOP = ttce_pkg::TAB_STOP_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ttce_pkg::t_dp_cmd     i_cmd,
    output ttce_pkg::t_dp_status  o_status,
    input  logic [1:0]            i_kind,
    input  logic [7:0]            i_char_code,
    input  logic [3:0]            i_back_colour,
    input  logic [3:0]            i_fore_colour,
    input  logic [6:0]            i_new_col,
    input  logic [4:0]            i_new_row,
    input  logic [10:0]           i_cell_index,
    output logic [6:0]            o_cursor_col,
    output logic [4:0]            o_cursor_row,
    output logic [10:0]           o_cursor_location,
    output logic                  o_scrolled,
    output logic [15:0]           o_cell_data
);

    localparam int NCELLS      = COLS * ROWS;
    localparam int AW          = $clog2(NCELLS);
    localparam int SHIFT_CELLS = (ROWS - 1) * COLS;
    localparam int NSTOPS      = (COLS - 1) / TAB_STOP + 1;

    logic [15:0]   mem [NCELLS];

    // Latched transaction.
    logic [1:0]    r_kind;
    logic [7:0]    r_char;
    logic [3:0]    r_back;
    logic [3:0]    r_fore;
    logic [6:0]    r_new_col;
    logic [4:0]    r_new_row;
    logic [10:0]   r_cell_index;

    logic [6:0]    r_col;
    logic [4:0]    r_row;
    logic          r_scrolled;
    logic          r_read_ok;
    logic [15:0]   r_rdata;

    // Sweep engine: each write lands in the cycle after its matching read.
    logic [AW-1:0] r_cnt;
    logic          r_wb_valid;
    logic          r_wb_copy;
    logic [AW-1:0] r_wb_addr;

    logic [7:0]    tab_next;
    logic [7:0]    col_wide;
    logic [5:0]    row_wide;
    logic [6:0]    wr_col;
    logic          put_we;
    logic [15:0]   put_word;
    logic          need_scroll;
    logic [AW-1:0] put_addr;
    logic          read_ok;
    logic          sweep_last;
    logic          copy_now;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;

    // Next tab stop: the lowest multiple of the stop width above the column.
    always_comb begin
        tab_next = 8'(NSTOPS * TAB_STOP);
        for (int m = NSTOPS; m >= 1; m--) begin
            if (8'(m * TAB_STOP) > {1'b0, r_col}) begin
                tab_next = 8'(m * TAB_STOP);
            end
        end
    end

    always_comb begin
        col_wide = {1'b0, r_col};
        row_wide = {1'b0, r_row};
        wr_col   = r_col;
        put_we   = 1'b0;
        put_word = {r_back, r_fore, r_char};
        case (r_char)
            ttce_pkg::CH_BS: begin
                if (r_col != 7'd0) begin
                    col_wide = col_wide - 8'd1;
                    wr_col   = r_col - 7'd1;
                    put_we   = 1'b1;
                    put_word = {r_back, r_fore, ttce_pkg::CH_SPACE};
                end else begin
                    if (r_row != 5'd0) begin
                        row_wide = row_wide - 6'd1;
                    end
                    col_wide = 8'd0;
                end
            end
            ttce_pkg::CH_TAB: begin
                col_wide = tab_next;
            end
            ttce_pkg::CH_CR: begin
                col_wide = 8'd0;
            end
            ttce_pkg::CH_LF: begin
                put_we   = 1'b1;
                put_word = ttce_pkg::BLANK_BLACK;
                col_wide = 8'd0;
                row_wide = row_wide + 6'd1;
            end
            default: begin
                if (r_char >= ttce_pkg::CH_SPACE && r_char <= ttce_pkg::CH_LAST_PRINT) begin
                    put_we   = 1'b1;
                    col_wide = col_wide + 8'd1;
                end
            end
        endcase
        if (col_wide >= 8'(COLS)) begin
            col_wide = 8'd0;
            row_wide = row_wide + 6'd1;
        end
        need_scroll = (row_wide >= 6'(ROWS));
        if (need_scroll) begin
            row_wide = 6'(ROWS - 1);
        end
    end

    assign put_addr   = AW'(32'(r_row) * COLS + 32'(wr_col));
    assign read_ok    = (32'(r_cell_index) < 32'(NCELLS));
    assign sweep_last = (r_cnt == AW'(NCELLS - 1));
    assign copy_now   = i_cmd.sweep_copy && (r_cnt < AW'(SHIFT_CELLS));

    assign mem_re    = (i_cmd.exec && r_kind == ttce_pkg::KIND_READ && read_ok)
                     || (i_cmd.sweep_run && copy_now);
    assign mem_raddr = i_cmd.sweep_run ? AW'(32'(r_cnt) + COLS) : AW'(r_cell_index);

    // A put never overlaps a sweep write-back: sweeps end before the next transaction.
    assign mem_we    = (i_cmd.exec && r_kind == ttce_pkg::KIND_PUT && put_we) || r_wb_valid;
    assign mem_waddr = r_wb_valid ? r_wb_addr : put_addr;
    assign mem_wdata = r_wb_valid ? (r_wb_copy ? r_rdata : ttce_pkg::BLANK_WHITE) : put_word;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_cnt      <= '0;
            r_wb_valid <= 1'b0;
        end else begin
            r_wb_valid <= i_cmd.sweep_run;
            if (i_cmd.sweep_run) begin
                r_cnt <= sweep_last ? '0 : r_cnt + AW'(1);
            end else begin
                r_cnt <= '0;
            end
            if (i_cmd.exec) begin
                case (r_kind)
                    ttce_pkg::KIND_PUT: begin
                        r_col <= col_wide[6:0];
                        r_row <= row_wide[4:0];
                    end
                    ttce_pkg::KIND_SET: begin
                        r_col <= ({1'b0, r_new_col} < 8'(COLS)) ? r_new_col : 7'(COLS - 1);
                        r_row <= ({1'b0, r_new_row} < 6'(ROWS)) ? r_new_row : 5'(ROWS - 1);
                    end
                    ttce_pkg::KIND_CLEAR: begin
                        r_col <= '0;
                        r_row <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind       <= i_kind;
            r_char       <= i_char_code;
            r_back       <= i_back_colour;
            r_fore       <= i_fore_colour;
            r_new_col    <= i_new_col;
            r_new_row    <= i_new_row;
            r_cell_index <= i_cell_index;
        end
        if (i_cmd.exec) begin
            r_scrolled <= (r_kind == ttce_pkg::KIND_PUT) && need_scroll;
            r_read_ok  <= read_ok;
        end
        r_wb_copy <= copy_now;
        r_wb_addr <= r_cnt;
    end

    assign o_status.kind        = r_kind;
    assign o_status.need_scroll = need_scroll;
    assign o_status.sweep_last  = sweep_last;

    assign o_cursor_col      = r_col;
    assign o_cursor_row      = r_row;
    assign o_cursor_location = 11'(32'(r_row) * COLS + 32'(r_col));
    assign o_scrolled        = r_scrolled;
    assign o_cell_data       = (r_kind == ttce_pkg::KIND_READ && r_read_ok) ? r_rdata : 16'd0;

endmodule

// ===== rtl/ttce_checker.sv =====
// Port-level checks for the text terminal cursor engine, bound to its top level.
module ttce_checker #(
    parameter int COLS = ttce_pkg::COLS_DEFAULT,
    parameter int ROWS = ttce_pkg::ROWS_DEFAULT
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [6:0]  o_cursor_col,
    input logic [4:0]  o_cursor_row,
    input logic [10:0] o_cursor_location,
    input logic        o_scrolled
);

    // An accepted transaction must raise busy; the block keeps it high until its result has gone out.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted transaction");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_cursor_col) < COLS) && (32'(o_cursor_row) < ROWS))
        else $error("cursor outside the screen");

    a_location: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cursor_location == 11'(32'(o_cursor_row) * COLS + 32'(o_cursor_col))))
        else $error("cursor location does not match row and column");

    // A scroll always leaves the cursor on the bottom row.
    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_scrolled) |-> (o_cursor_row == 5'(ROWS - 1)))
        else $error("scroll left the cursor off the bottom row");

endmodule

bind text_terminal_cursor_engine_top ttce_checker #(
    .COLS (COLS),
    .ROWS (ROWS)
) u_ttce_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_valid           (o_valid),
    .o_cursor_col      (o_cursor_col),
    .o_cursor_row      (o_cursor_row),
    .o_cursor_location (o_cursor_location),
    .o_scrolled        (o_scrolled)
);
